// ===== src/battery_cell_soc_estimator_macros.svh =====
// Assertion macros shared by the SOC estimator RTL.
`ifndef BATTERY_CELL_SOC_ESTIMATOR_MACROS_SVH
`define BATTERY_CELL_SOC_ESTIMATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define BCSE_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define BCSE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`else
`define BCSE_ASSERT(name, clk, rst, prop)
`define BCSE_ASSERT_IMPLY(name, clk, rst, ante, cons)
`endif
`endif

// ===== src/bcse_pkg.sv =====
// Shared types and constants of the SOC estimator.
package bcse_pkg;
   localparam int MAX_CELLS_DEF = 128;
   localparam int OCV_DEPTH_DEF = 32;
   localparam int SOC_FULL      = 25600;
   localparam int DIV_W         = 48;
   localparam int DVR_W         = 32;
   localparam int DIV_CNT_W     = $clog2(DIV_W + 1);
   localparam int CAP_W         = 40;
   localparam int CELL_W        = 32 + 16 + CAP_W;
   // capacity step: x*256/36000 == x*8/1125
   localparam int     STEP_DIV_ODD  = 1125;
   localparam longint STEP_RECIP    = 488671835;   // ceil(2^39 / 1125)
   localparam int     STEP_RECIP_SH = 39;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_TABLE = 2'd1,
      ST_SKIP  = 2'd2
   } status_type;

   typedef enum logic {
      ACT_SAMPLE = 1'b0,
      ACT_TABLE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      REG_CELLS    = 2'd0,
      REG_NOMINAL  = 2'd1,
      REG_OCV_SIZE = 2'd2,
      REG_REST_THR = 2'd3
   } reg_index_type;
endpackage

// ===== src/battery_cell_soc_estimator.sv =====
// Top level of the cell SOC estimator: sequencer, cell and OCV memories, divider.
`include "battery_cell_soc_estimator_macros.svh"
// Takes one request at a time. An OCV table write or a skipped sample goes from
// acceptance straight to the output state. A sample in initial (OCV) mode reads
// its cell, walks the OCV table with a read and a compare per entry and then
// runs two divisions by the table size; with an empty table it skips the walk and
// the divisions. A sample in coulomb-counting mode reads its cell, forms the
// capacity step by radix-2^16 reciprocal division by the fixed time scale, adds
// it and then runs one (resting) or two divisions. Divisions by table size,
// current and nominal capacity share one serial divider. The next request can
// be taken as soon as the response is registered. Per-cell state lives in one RAM
// (capacity, resting voltage, resistance); the resting voltage and resistance read
// as zero until a cell is first written, tracked by one valid flag per cell, so no
// clearing pass runs after reset. A finished response waits in the output register
// while the next request is taken; a response not yet taken holds the sequencer in
// its last state.
module battery_cell_soc_estimator import bcse_pkg::*; #(
   parameter int MAX_CELLS = MAX_CELLS_DEF,
   parameter int OCV_DEPTH = OCV_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // index[6:0], voltage_mv[22:7], current_q8[46:23], cycle_time_ms[62:47]
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,   // last_cell
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_soc_q8[15:0], resistance_uohm[47:16], pack_min_soc_q8[63:48],
   // initial_done[64]
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,   // last_result
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
   localparam int OW = (OCV_DEPTH > 1) ? $clog2(OCV_DEPTH) : 1;
   localparam int JW = $clog2(OCV_DEPTH + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_LOAD, S_WALK_RD, S_WALK_CMP, S_ISOC, S_ICAP,
      S_STEP, S_ACC, S_RES, S_SOC, S_WB, S_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [7:0]  cells_ff, cells_in;
   logic [15:0] nom_ff, nom_in;
   logic [5:0]  ocv_size_ff, ocv_size_in;
   logic [15:0] thr_ff, thr_in;

   // pass state
   logic               done_ff, done_in;
   logic               abort_ff, abort_in;
   logic signed [15:0] min_ff, min_in;
   logic [MAX_CELLS-1:0] valid_ff, valid_in;
   logic               div_run_ff, div_run_in;

   // request and working registers
   logic [6:0]         idx_ff, idx_in;
   logic [15:0]        volt_ff, volt_in;
   logic signed [23:0] cur_ff, cur_in;
   logic [15:0]        ms_ff, ms_in;
   logic               last_ff, last_in;
   logic               zero_ff, zero_in;
   status_type         status_ff, status_in;
   logic               vld_rd_ff, vld_rd_in;
   logic               resting_ff, resting_in;
   logic [JW-1:0]      j_ff, j_in;
   logic signed [40:0] mp_ff, mp_in;
   logic signed [35:0] num_ff, num_in;
   logic signed [CAP_W-1:0] cap_ff, cap_in;
   logic [15:0]        rest_ff, rest_in;
   logic signed [31:0] resist_ff, resist_in;
   logic signed [15:0] soc_ff, soc_in;
   logic [47:0]        step_q_ff, step_q_in;
   logic [10:0]        step_r_ff, step_r_in;
   logic [1:0]         step_k_ff, step_k_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [71:0]        rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;
   status_type         rsp_user_ff, rsp_user_in;

   // memories and divider
   logic              ocv_we;
   logic [15:0]       ocv_rd;
   logic              cell_we;
   logic [CELL_W-1:0] cell_rd;
   logic              div_start, div_busy, div_done;
   logic [DIV_W-1:0]  div_dividend, div_quo;
   logic [DVR_W-1:0]  div_divisor;

   logic [15:0]        nom_eff;
   logic [JW-1:0]      size_w;
   logic [15:0]        rest_rd;
   logic [39:0]        mp_mag;
   logic [34:0]        num_mag;
   logic signed [46:0] cap100;
   logic [45:0]        cap_mag;
   logic [47:0]        step_x;
   logic [15:0]        cd_chunk;
   logic [26:0]        cd_part;
   logic [54:0]        cd_prod;
   logic [15:0]        cd_digit;
   logic [26:0]        cd_rem;
   logic signed [41:0] step_s;
   logic signed [41:0] cap_sum;
   logic [15:0]        soc_mag;
   logic signed [15:0] min_eff;
   logic               abort_eff;
   logic               done_next;
   logic               accept;

   assign accept  = req_tvalid && req_tready;
   assign nom_eff = (nom_ff == 16'd0) ? 16'd1 : nom_ff;
   assign size_w  = (9'(ocv_size_ff) > 9'(OCV_DEPTH)) ? JW'(OCV_DEPTH) : JW'(ocv_size_ff);
   assign rest_rd = vld_rd_ff ? cell_rd[55:40] : 16'd0;
   assign mp_mag  = mp_ff[40] ? 40'(-mp_ff) : 40'(mp_ff);
   assign num_mag = num_ff[35] ? 35'(-num_ff) : 35'(num_ff);
   assign cap100  = cap_ff * 47'sd100;
   assign cap_mag = cap100[46] ? 46'(-cap100) : 46'(cap100);

   // step magnitude = |cur*ms|*8/1125, long division one 16-bit digit per cycle;
   // each digit comes from a reciprocal multiply, remainder stays below 1125
   assign step_x   = {5'd0, mp_mag, 3'd0};
   assign cd_chunk = (step_k_ff == 2'd0) ? step_x[47:32] :
                     (step_k_ff == 2'd1) ? step_x[31:16] : step_x[15:0];
   assign cd_part  = {step_r_ff, cd_chunk};
   assign cd_prod  = 55'(cd_part) * 55'(STEP_RECIP);
   assign cd_digit = cd_prod[STEP_RECIP_SH+15:STEP_RECIP_SH];
   assign cd_rem   = cd_part - 27'(cd_digit) * 27'(STEP_DIV_ODD);

   bcse_ram #(.WIDTH(16), .DEPTH(OCV_DEPTH)) u_ocv_ram (
      .clock   (clock),
      .wr_en   (ocv_we),
      .wr_addr (OW'(req_tdata[6:0])),
      .wr_data (req_tdata[22:7]),
      .rd_addr (OW'(j_ff)),
      .rd_data (ocv_rd)
   );

   bcse_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CELLS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (CW'(idx_ff)),
      .wr_data ({resist_ff, rest_ff, cap_ff}),
      .rd_addr (CW'(idx_ff)),
      .rd_data (cell_rd)
   );

   bcse_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   // divider operands by phase
   always_comb begin
      div_dividend = '0;
      div_divisor  = '0;
      case (state_ff)
         S_ISOC: begin
            div_dividend = 48'(j_ff) * 48'd25600;
            div_divisor  = DVR_W'(size_w);
         end
         S_ICAP: begin
            div_dividend = (48'(j_ff) * 48'(nom_eff)) << 16;
            div_divisor  = DVR_W'(size_w);
         end
         S_RES: begin
            div_dividend = 48'(num_mag);
            div_divisor  = {9'd0, cur_ff[22:0]};
         end
         S_SOC: begin
            div_dividend = 48'(cap_mag);
            div_divisor  = {8'd0, nom_eff, 8'd0};
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cells_in     = cells_ff;
      nom_in       = nom_ff;
      ocv_size_in  = ocv_size_ff;
      thr_in       = thr_ff;
      done_in      = done_ff;
      abort_in     = abort_ff;
      min_in       = min_ff;
      valid_in     = valid_ff;
      div_run_in   = div_run_ff;
      idx_in       = idx_ff;
      volt_in      = volt_ff;
      cur_in       = cur_ff;
      ms_in        = ms_ff;
      last_in      = last_ff;
      zero_in      = zero_ff;
      status_in    = status_ff;
      vld_rd_in    = vld_rd_ff;
      resting_in   = resting_ff;
      j_in         = j_ff;
      mp_in        = mp_ff;
      num_in       = num_ff;
      cap_in       = cap_ff;
      rest_in      = rest_ff;
      resist_in    = resist_ff;
      soc_in       = soc_ff;
      step_q_in    = step_q_ff;
      step_r_in    = step_r_ff;
      step_k_in    = step_k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      ocv_we       = 1'b0;
      cell_we      = 1'b0;
      div_start    = 1'b0;
      step_s       = '0;
      cap_sum      = '0;
      soc_mag      = '0;
      min_eff      = min_ff;
      abort_eff    = abort_ff;
      done_next    = done_ff;

      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_CELLS:    cells_in    = csr_wdata[7:0];
            REG_NOMINAL:  nom_in      = csr_wdata;
            REG_OCV_SIZE: ocv_size_in = csr_wdata[5:0];
            REG_REST_THR: thr_in      = csr_wdata;
            default:      cells_in    = cells_ff;
         endcase
      end

      // common start/wait handshake for the divider phases
      if (state_ff == S_ISOC || state_ff == S_ICAP ||
          state_ff == S_RES || state_ff == S_SOC) begin
         if (!div_run_ff) begin
            div_start  = 1'b1;
            div_run_in = 1'b1;
         end else if (div_done) begin
            div_run_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in    = req_tdata[6:0];
               volt_in   = req_tdata[22:7];
               cur_in    = $signed(req_tdata[46:23]);
               ms_in     = req_tdata[62:47];
               last_in   = req_tlast;
               zero_in   = 1'b0;
               soc_in    = '0;
               resist_in = '0;
               if (action_type'(req_tuser) == ACT_TABLE) begin
                  ocv_we    = 9'(req_tdata[6:0]) < 9'(OCV_DEPTH);
                  status_in = ST_TABLE;
                  state_in  = S_OUT;
               end else if ({1'b0, req_tdata[6:0]} >= cells_ff ||
                            9'(req_tdata[6:0]) >= 9'(MAX_CELLS)) begin
                  status_in = ST_SKIP;
                  state_in  = S_OUT;
               end else if (!done_ff && req_tdata[22:7] == 16'd0) begin
                  zero_in   = 1'b1;
                  status_in = ST_SKIP;
                  state_in  = S_OUT;
               end else begin
                  status_in = ST_DONE;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            vld_rd_in = valid_ff[CW'(idx_ff)];
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            cap_in    = $signed(cell_rd[CAP_W-1:0]);
            rest_in   = rest_rd;
            resist_in = vld_rd_ff ? $signed(cell_rd[87:56]) : 32'sd0;
            if (!done_ff) begin
               j_in = '0;
               if (size_w == '0) begin
                  // empty table reads as full charge
                  soc_in   = 16'(SOC_FULL);
                  cap_in   = $signed({8'd0, nom_eff, 16'd0});
                  state_in = S_WB;
               end else begin
                  state_in = S_WALK_RD;
               end
            end else begin
               mp_in      = cur_ff * $signed({1'b0, ms_ff});
               num_in     = ($signed({1'b0, rest_rd}) - $signed({1'b0, volt_ff}))
                            * 36'sd256000;
               resting_in = $signed({cur_ff[23], cur_ff}) <= $signed({9'd0, thr_ff});
               if ($signed({cur_ff[23], cur_ff}) <= $signed({9'd0, thr_ff})) begin
                  rest_in = volt_ff;
               end
               step_q_in = '0;
               step_r_in = '0;
               step_k_in = '0;
               state_in  = S_STEP;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_CMP;
         end
         S_WALK_CMP: begin
            // no entry above the voltage ends with j = size, i.e. full charge
            if (volt_ff < ocv_rd) begin
               state_in = S_ISOC;
            end else begin
               j_in = j_ff + 1'b1;
               state_in = (j_ff + 1'b1 >= size_w) ? S_ISOC : S_WALK_RD;
            end
         end
         S_ISOC: begin
            if (div_run_ff && div_done) begin
               soc_in   = $signed(div_quo[15:0]);
               state_in = S_ICAP;
            end
         end
         S_ICAP: begin
            if (div_run_ff && div_done) begin
               cap_in   = $signed(div_quo[CAP_W-1:0]);
               state_in = S_WB;
            end
         end
         S_STEP: begin
            step_q_in = {step_q_ff[31:0], cd_digit};
            step_r_in = cd_rem[10:0];
            step_k_in = step_k_ff + 1'b1;
            if (step_k_ff == 2'd2) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            step_s  = mp_ff[40] ? -$signed({1'b0, step_q_ff[40:0]})
                                :  $signed({1'b0, step_q_ff[40:0]});
            cap_sum = 42'(cap_ff) + step_s;
            if (cap_sum[41:39] == 3'b000 || cap_sum[41:39] == 3'b111) begin
               cap_in = cap_sum[CAP_W-1:0];
            end else begin
               cap_in = cap_sum[41] ? {1'b1, {(CAP_W-1){1'b0}}}
                                    : {1'b0, {(CAP_W-1){1'b1}}};
            end
            state_in = resting_ff ? S_SOC : S_RES;
         end
         S_RES: begin
            if (div_run_ff && div_done) begin
               if (!num_ff[35]) begin
                  resist_in = (div_quo > 48'd2147483647) ? 32'sh7fff_ffff
                                                         : $signed(div_quo[31:0]);
               end else begin
                  resist_in = (div_quo > 48'd2147483648) ? 32'sh8000_0000
                                                         : $signed(32'(48'd0 - div_quo));
               end
               state_in = S_SOC;
            end
         end
         S_SOC: begin
            soc_mag = (div_quo > 48'(SOC_FULL)) ? 16'(SOC_FULL) : div_quo[15:0];
            if (div_run_ff && div_done) begin
               soc_in   = cap_ff[CAP_W-1] ? $signed(16'd0 - soc_mag) : $signed(soc_mag);
               state_in = S_WB;
            end
         end
         S_WB: begin
            cell_we = 1'b1;
            valid_in[CW'(idx_ff)] = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status_ff != ST_TABLE) begin
               min_eff   = (status_ff == ST_DONE && soc_ff < min_ff) ? soc_ff : min_ff;
               abort_eff = abort_ff || zero_ff;
               done_next = (last_ff && !abort_eff) ? 1'b1 : done_ff;
            end
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff;
               rsp_user_in  = status_ff;
               rsp_data_in  = {7'd0, done_next,
                               (last_ff && status_ff != ST_TABLE && !abort_eff)
                                  ? min_eff : 16'sd0,
                               resist_ff, soc_ff};
               if (status_ff != ST_TABLE) begin
                  done_in = done_next;
                  if (last_ff) begin
                     min_in   = 16'(SOC_FULL);
                     abort_in = 1'b0;
                  end else begin
                     min_in   = min_eff;
                     abort_in = abort_eff;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cells_ff     <= 8'd1;
         nom_ff       <= 16'd1000;
         ocv_size_ff  <= 6'd1;
         thr_ff       <= 16'd1280;
         done_ff      <= 1'b0;
         abort_ff     <= 1'b0;
         min_ff       <= 16'(SOC_FULL);
         valid_ff     <= '0;
         div_run_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cells_ff     <= cells_in;
         nom_ff       <= nom_in;
         ocv_size_ff  <= ocv_size_in;
         thr_ff       <= thr_in;
         done_ff      <= done_in;
         abort_ff     <= abort_in;
         min_ff       <= min_in;
         valid_ff     <= valid_in;
         div_run_ff   <= div_run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      volt_ff     <= volt_in;
      cur_ff      <= cur_in;
      ms_ff       <= ms_in;
      last_ff     <= last_in;
      zero_ff     <= zero_in;
      status_ff   <= status_in;
      vld_rd_ff   <= vld_rd_in;
      resting_ff  <= resting_in;
      j_ff        <= j_in;
      mp_ff       <= mp_in;
      num_ff      <= num_in;
      cap_ff      <= cap_in;
      rest_ff     <= rest_in;
      resist_ff   <= resist_in;
      soc_ff      <= soc_in;
      step_q_ff   <= step_q_in;
      step_r_ff   <= step_r_in;
      step_k_ff   <= step_k_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   `BCSE_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_start, !div_busy)
   `BCSE_ASSERT(a_no_wb_after_req, clock, reset, req_tvalid && req_tready |=> !cell_we)
   `BCSE_ASSERT(a_done_sticky, clock, reset, !$fell(done_ff))
   `BCSE_ASSERT_IMPLY(a_skip_zero, clock, reset, rsp_tvalid && rsp_tuser != ST_DONE, rsp_tdata[47:0] == 48'd0)
   `BCSE_ASSERT_IMPLY(a_pmin_on_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[63:48] == 16'd0)
endmodule

// ===== src/bcse_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bcse_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/bcse_div.sv =====
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
module bcse_div import bcse_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DVR_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);
   logic [DVR_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DVR_W-1:0]     dvr_ff, dvr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVR_W:0]       trial;
   logic [DVR_W:0]       diff;
   logic                 ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvr_ff};
      ge      = trial >= {1'b0, dvr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvr_in  = dvr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvr_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvr_ff <= dvr_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== verif/battery_cell_soc_estimator_checker.sv =====
// Checker for the SOC estimator: mirrors registers, predicts each response and compares.
module battery_cell_soc_estimator_checker import bcse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   localparam longint CAP_HI = 64'sd549755813887;
   localparam longint CAP_LO = -64'sd549755813888;

   typedef struct {
      logic [15:0] soc;
      logic [31:0] res;
      logic [15:0] pmin;
      logic        init;
      status_type  status;
      logic        last;
   } soc_result_type;

   soc_result_type soc_expected[$];

   logic [7:0]  cells_cfg;
   logic [15:0] nominal_cfg;
   logic [5:0]  ocv_size_cfg;
   logic [15:0] rest_thr_cfg;

   bit          init_done;
   bit          aborted;
   longint      min_soc;
   logic [15:0] ocv_mv [OCV_DEPTH_DEF];
   longint      capacity [MAX_CELLS_DEF];
   logic [15:0] rest_mv [MAX_CELLS_DEF];
   longint      resist [MAX_CELLS_DEF];

   assign pending = soc_expected.size();

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic predict_request(input logic act, input logic [63:0] d, input logic last);
      logic [6:0]  idx;
      logic [15:0] volt;
      longint      cur, ms, nom, soc, res, pmin, cap;
      int          size, j;
      bit          found;
      soc_result_type r;
      idx  = d[6:0];
      volt = d[22:7];
      cur  = longint'($signed(d[46:23]));
      ms   = longint'({1'b0, d[62:47]});
      soc  = 0;
      res  = 0;
      pmin = 0;
      r.last = last;
      if (action_type'(act) == ACT_TABLE) begin
         if (idx < OCV_DEPTH_DEF) ocv_mv[idx] = volt;
         r.status = ST_TABLE;
      end else begin
         nom = (nominal_cfg == 0) ? 1 : longint'({1'b0, nominal_cfg});
         if (idx >= cells_cfg) begin
            r.status = ST_SKIP;
         end else if (!init_done && volt == 0) begin
            aborted = 1;
            r.status = ST_SKIP;
         end else if (!init_done) begin
            size = (ocv_size_cfg > OCV_DEPTH_DEF) ? OCV_DEPTH_DEF : ocv_size_cfg;
            found = 0;
            for (j = 0; j < size; j++)
               if (volt < ocv_mv[j]) begin
                  found = 1;
                  break;
               end
            if (found) begin
               soc = (longint'(j) * SOC_FULL) / size;
               capacity[idx] = (longint'(j) * nom * 65536) / size;
            end else begin
               soc = SOC_FULL;
               capacity[idx] = nom * 65536;
            end
            res = resist[idx];
            r.status = ST_DONE;
         end else begin
            if (cur <= longint'({1'b0, rest_thr_cfg}))
               rest_mv[idx] = volt;
            else
               resist[idx] = clip(((longint'({1'b0, rest_mv[idx]}) - longint'({1'b0, volt}))
                                   * 256000) / cur, -64'sd2147483648, 64'sd2147483647);
            cap = clip(capacity[idx] + (cur * ms * 256) / 36000, CAP_LO, CAP_HI);
            capacity[idx] = cap;
            soc = clip((cap * 100) / (nom * 256), -SOC_FULL, SOC_FULL);
            res = resist[idx];
            r.status = ST_DONE;
         end
         if (r.status == ST_DONE && soc < min_soc) min_soc = soc;
         if (last) begin
            pmin = aborted ? 0 : min_soc;
            if (!aborted) init_done = 1;
            min_soc = SOC_FULL;
            aborted = 0;
         end
      end
      r.soc  = soc[15:0];
      r.res  = res[31:0];
      r.pmin = pmin[15:0];
      r.init = init_done;
      soc_expected.push_back(r);
   endtask

   task automatic check_response();
      soc_result_type w;
      if (soc_expected.size() == 0) begin
         report("unexpected response", rsp_tdata[15:0], 0);
         return;
      end
      w = soc_expected.pop_front();
      if (rsp_tdata[15:0] !== w.soc)
         report("cell_soc", $signed(rsp_tdata[15:0]), $signed(w.soc));
      if (rsp_tdata[47:16] !== w.res)
         report("resistance", $signed(rsp_tdata[47:16]), $signed(w.res));
      if (rsp_tdata[63:48] !== w.pmin)
         report("pack_min_soc", $signed(rsp_tdata[63:48]), $signed(w.pmin));
      if (rsp_tdata[64] !== w.init) report("initial_done", rsp_tdata[64], w.init);
      if (rsp_tuser !== w.status) report("status", rsp_tuser, w.status);
      if (rsp_tlast !== w.last) report("last", rsp_tlast, w.last);
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         cells_cfg    <= 8'd1;
         nominal_cfg  <= 16'd1000;
         ocv_size_cfg <= 6'd1;
         rest_thr_cfg <= 16'd1280;
         init_done = 0;
         aborted   = 0;
         min_soc   = SOC_FULL;
         for (int i = 0; i < MAX_CELLS_DEF; i++) begin
            rest_mv[i] = 0;
            resist[i]  = 0;
            capacity[i] = 0;
         end
      end else begin
         if (csr_we)
            case (reg_index_type'(csr_addr))
               REG_CELLS:    cells_cfg    <= csr_wdata[7:0];
               REG_NOMINAL:  nominal_cfg  <= csr_wdata;
               REG_OCV_SIZE: ocv_size_cfg <= csr_wdata[5:0];
               REG_REST_THR: rest_thr_cfg <= csr_wdata;
               default:      ;
            endcase
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready) predict_request(req_tuser, req_tdata, req_tlast);
      end
   end

   final if (soc_expected.size() != 0) $display("responses still outstanding: %0d", pending);
endmodule

// ===== verif/tb_top.sv =====
// Top of the SOC estimator testbench: clock, reset, request stimulus and verdict.
module tb_top;
   import bcse_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic        csr_we = 0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;
   int          fail_count;
   int          pending;
   int          rsp_hold = 0;
   bit          calm = 0;
   int          n_cells = 1;

   always #6 clock = ~clock;

   battery_cell_soc_estimator u_dut (.*);

   battery_cell_soc_estimator_checker u_checker (.*);

   // Response side inserts a random stall after each response, except in calm stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_hold = calm ? 0 : $urandom_range(7);
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= (rsp_hold == 0);
      end else begin
         rsp_tready <= 1;
      end
   end

   task automatic send_request(input action_type act, input int idx, input int volt,
                               input int cur, input int ms, input bit last);
      int gap;
      gap = calm ? 0 : $urandom_range(7);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= act;
      req_tlast  <= last;
      req_tdata  <= {1'b0, ms[15:0], cur[23:0], volt[15:0], idx[6:0]};
      req_tvalid <= 1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type a, input int v);
      csr_we    <= 1;
      csr_addr  <= a;
      csr_wdata <= v[15:0];
      @(posedge clock);
      csr_we    <= 0;
      if (a == REG_CELLS) n_cells = v & 8'hff;
   endtask

   function automatic int pick_current();
      case ($urandom_range(4))
         0: return $urandom_range(2048);
         1: return -int'($urandom_range(4096));
         2: return $urandom_range(65535);
         3: return $urandom_range(70000, 1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_sample(input bit init_mode, input bit last);
      int idx, volt, lim;
      lim = (n_cells > 128) ? 128 : n_cells;
      if (lim == 0 || $urandom_range(9) == 0) idx = $urandom_range(127);
      else idx = $urandom_range(lim - 1);
      // zero voltage also hits the abort path while still in OCV mode
      volt = ($urandom_range(11) == 0) ? 0 : $urandom_range(65535);
      if (init_mode && volt == 0 && $urandom_range(1)) volt = $urandom_range(4500, 2900);
      send_request(ACT_SAMPLE, idx, volt, pick_current(), $urandom_range(65535), last);
   endtask

   initial begin
      int sizes[5] = '{0, 1, 7, 32, 63};
      int cell_opts[6] = '{0, 1, 4, 128, 255, 17};
      int nom_opts[5] = '{0, 1, 65535, 1000, 3};
      int len;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // OCV table, rising, plus an ignored out-of-range entry
      for (int j = 0; j < 32; j++)
         send_request(ACT_TABLE, j, 3000 + 40 * j, 0, 0, 0);
      send_request(ACT_TABLE, 127, 65535, 0, 0, 1);
      drain();
      write_reg(REG_CELLS, 4);
      write_reg(REG_OCV_SIZE, 32);
      send_request(ACT_SAMPLE, 0, 0, 0, 0, 0);
      send_request(ACT_SAMPLE, 1, 65535, 0, 0, 0);
      send_request(ACT_SAMPLE, 2, 2999, 0, 0, 0);
      send_request(ACT_SAMPLE, 5, 3500, 0, 0, 0);
      send_request(ACT_SAMPLE, 3, 3100, 0, 0, 1);
      // closing an aborted pass on a skipped sample
      send_request(ACT_SAMPLE, 0, 0, 0, 0, 0);
      send_request(ACT_SAMPLE, 9, 3100, 0, 0, 1);

      // OCV-mode passes, each kept aborted by a zero voltage
      for (int p = 0; p < 8; p++) begin
         drain();
         write_reg(REG_OCV_SIZE, sizes[p % 5]);
         write_reg(REG_CELLS, $urandom_range(8, 1));
         len = $urandom_range(10, 3);
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(7) == 0)
               send_request(ACT_TABLE, $urandom_range(127), $urandom_range(65535),
                            $urandom, $urandom, $urandom_range(1));
            else random_sample(1, 0);
         end
         send_request(ACT_SAMPLE, 0, 0, 0, 0, 1);
      end

      // full clean pass seeds every cell capacity and ends OCV mode
      drain();
      write_reg(REG_CELLS, 128);
      write_reg(REG_OCV_SIZE, $urandom_range(32, 1));
      for (int c = 0; c < 128; c++)
         send_request(ACT_SAMPLE, c, $urandom_range(65535, 1), 0, 0, c == 127);

      // coulomb counting phases across register settings
      for (int p = 0; p < 9; p++) begin
         drain();
         write_reg(REG_CELLS, cell_opts[p % 6]);
         write_reg(REG_NOMINAL, (p < 5) ? nom_opts[p] : $urandom_range(65535));
         write_reg(REG_REST_THR, (p == 0) ? 0 : (p == 1) ? 65535 : $urandom_range(4000));
         write_reg(REG_OCV_SIZE, $urandom_range(63));
         calm = (p % 3 == 2);
         for (int k = 0; k < 100; k++) begin
            if (k == 50) drain();
            if ($urandom_range(15) == 0) calm = ~calm;
            if ($urandom_range(9) == 0)
               send_request(ACT_TABLE, $urandom_range(127), $urandom_range(65535),
                            $urandom, $urandom, $urandom_range(1));
            else random_sample(0, $urandom_range(7) == 0);
         end
         send_request(ACT_SAMPLE, 0, $urandom_range(65535), pick_current(), 1000, 1);
      end

      drain();
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("PASS battery_cell_soc_estimator");
      else $display("FAIL battery_cell_soc_estimator");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAIL battery_cell_soc_estimator");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/bcse_pkg.sv
src/bcse_ram.sv
src/bcse_div.sv
src/battery_cell_soc_estimator.sv
verif/battery_cell_soc_estimator_checker.sv
verif/tb_top.sv
